FILE: rtl/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg
// Shared constants, action codes and the controller/datapath interface types
// of the chained hash set.
// ----------------------------------------------------------------------------
package chs_pkg;

    // defaults for the top-level parameters
    localparam int BUCKETS_DEF   = 1024;
    localparam int NODES_DEF     = 4096;
    localparam int SITE_BITS_DEF = 32;

    // fixed field widths
    localparam int ACTION_W = 2;
    localparam int SITE_W   = 32;
    localparam int MASK_W   = 10;
    localparam int TOTAL_W  = 13;
    localparam int M_DATA_W = 16;

    localparam logic [MASK_W-1:0] MASK_RESET = 10'h3FF;

    // hash: 17*site - 97
    localparam int HASH_MUL = 17;
    localparam int HASH_SUB = 97;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NOP    = 2'd3;

    typedef struct packed {
        logic load_item;
        logic rem_start;
        logic rem_step;
        logic head_insert;   // write node at count, relink head, bump count
        logic head_clear;
        logic sweep_step;
        logic ptr_from_head;
        logic ptr_from_link;
        logic count_clear;
        logic emit;
        logic emit_found;
        logic emit_full;
    } cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                idx_big;
        logic                pool_full;
        logic                head_valid;
        logic                link_valid;
        logic                site_match;
        logic                sweep_last;
        logic                out_free;
    } sts_t;

endpackage

FILE: rtl/chs_dp.sv
// ----------------------------------------------------------------------------
// chs_dp
// Datapath: bucket mask register, hash, reciprocal bucket reduction, head
// table, node pool, entry counter and the result register.
// ----------------------------------------------------------------------------
module chs_dp #(
    parameter int BUCKETS   = chs_pkg::BUCKETS_DEF,
    parameter int NODES     = chs_pkg::NODES_DEF,
    parameter int SITE_BITS = chs_pkg::SITE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  chs_pkg::cmd_t                 cmd,
    output chs_pkg::sts_t                 sts,
    input  logic [chs_pkg::ACTION_W-1:0]  s_action,
    input  logic [chs_pkg::SITE_W-1:0]    s_site,
    input  logic                          cfg_wen,
    input  logic [chs_pkg::MASK_W-1:0]    cfg_wdata,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic                          m_full,
    output logic [chs_pkg::TOTAL_W-1:0]   m_total
);

    localparam int MW     = chs_pkg::MASK_W;
    localparam int TW     = chs_pkg::TOTAL_W;
    localparam int BK_W   = $clog2(BUCKETS);
    localparam int ND_W   = $clog2(NODES);
    localparam int CNT_W  = $clog2(NODES + 1);
    localparam int SW     = (SITE_BITS < chs_pkg::SITE_W) ? SITE_BITS : chs_pkg::SITE_W;
    localparam int HB     = (SITE_BITS < MW) ? SITE_BITS : MW;
    localparam logic [MW-1:0]   HMASK  = MW'((33'd1 << HB) - 33'd1);
    localparam logic [BK_W-1:0] LAST_B = BK_W'(BUCKETS - 1);
    // quotient of an MW-bit index by BUCKETS: (idx * RECIP) >> RSH, exact
    localparam int              RSH     = MW + BK_W;
    localparam longint          RECIP_L = ((longint'(1) << RSH) + longint'(BUCKETS)
                                           - longint'(1)) / longint'(BUCKETS);
    localparam logic [MW:0]     RECIP   = (MW + 1)'(RECIP_L);
    localparam logic [MW-1:0]   BUCK_M  = MW'(BUCKETS);

    logic [MW-1:0]                 mask_reg;
    logic [chs_pkg::ACTION_W-1:0]  action_reg;
    logic [SW-1:0]                 site_reg;
    logic [MW-1:0]                 idx_reg;
    logic [MW-1:0]                 quo_reg;
    logic [BK_W-1:0]               sweep_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [ND_W-1:0]               ptr_reg;
    logic                          m_valid_reg;
    logic                          m_found_reg;
    logic                          m_full_reg;
    logic [TW-1:0]                 m_total_reg;

    logic [MW-1:0]   s_low;
    logic [MW-1:0]   hash_low;
    logic [2*MW:0]   quo_prod;
    logic [2*MW-1:0] back_prod;
    logic [BK_W-1:0] head_addr;
    logic [BK_W-1:0] head_waddr;
    logic [ND_W:0]   head_wdata;
    logic            head_we;
    logic [ND_W-1:0] node_waddr;

    // memories: head = {valid, ptr}, link = {valid, ptr}
    logic [ND_W:0]   head_mem [BUCKETS];
    logic [SW-1:0]   site_mem [NODES];
    logic [ND_W:0]   link_mem [NODES];
    logic [ND_W:0]   head_q;
    logic [SW-1:0]   site_q;
    logic [ND_W:0]   link_q;

    // only the low MW bits of the hash reach the mask
    assign s_low    = s_site[MW-1:0];
    assign hash_low = s_low * MW'(chs_pkg::HASH_MUL) - MW'(chs_pkg::HASH_SUB);

    assign quo_prod  = (2*MW + 1)'(idx_reg) * (2*MW + 1)'(RECIP);
    assign back_prod = (2*MW)'(quo_reg) * (2*MW)'(BUCK_M);

    assign head_addr  = BK_W'(idx_reg);
    assign node_waddr = count_reg[ND_W-1:0];
    assign head_we    = cmd.head_clear || cmd.head_insert;
    assign head_waddr = cmd.head_clear ? sweep_reg : head_addr;
    assign head_wdata = cmd.head_clear ? '0 : {1'b1, node_waddr};

    always_comb begin
        count_next = count_reg;
        if (cmd.count_clear) begin
            count_next = '0;
        end else if (cmd.head_insert) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= chs_pkg::MASK_RESET;
            sweep_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wen) begin
                mask_reg <= cfg_wdata;
            end
            if (cmd.sweep_step) begin
                sweep_reg <= (sweep_reg == LAST_B) ? '0 : sweep_reg + BK_W'(1);
            end
            count_reg <= count_next;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            action_reg <= s_action;
            site_reg   <= s_site[SW-1:0];
            idx_reg    <= hash_low & HMASK & mask_reg;
        end else if (cmd.rem_step) begin
            idx_reg <= idx_reg - back_prod[MW-1:0];
        end
        if (cmd.rem_start) begin
            quo_reg <= MW'(quo_prod >> RSH);
        end
        if (cmd.ptr_from_head) begin
            ptr_reg <= head_q[ND_W-1:0];
        end else if (cmd.ptr_from_link) begin
            ptr_reg <= link_q[ND_W-1:0];
        end
        if (cmd.emit) begin
            m_found_reg <= cmd.emit_found;
            m_full_reg  <= cmd.emit_full;
            m_total_reg <= TW'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (head_we) begin
            head_mem[head_waddr] <= head_wdata;
        end
        head_q <= head_mem[head_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.head_insert) begin
            site_mem[node_waddr] <= site_reg;
            link_mem[node_waddr] <= head_q;
        end
        site_q <= site_mem[ptr_reg];
        link_q <= link_mem[ptr_reg];
    end

    assign sts.action     = action_reg;
    assign sts.idx_big    = (32'(idx_reg) >= BUCKETS);
    assign sts.pool_full  = (32'(count_reg) >= NODES);
    assign sts.head_valid = head_q[ND_W];
    assign sts.link_valid = link_q[ND_W];
    assign sts.site_match = (site_q == site_reg);
    assign sts.sweep_last = (sweep_reg == LAST_B);
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_found = m_found_reg;
    assign m_full  = m_full_reg;
    assign m_total = m_total_reg;

endmodule

FILE: rtl/chs_ctrl.sv
// ----------------------------------------------------------------------------
// chs_ctrl
// Controller: sequences head sweep, hashing, bucket reduction, insert, chain
// walk and result hand-off.
// ----------------------------------------------------------------------------
module chs_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  chs_pkg::sts_t sts,
    output chs_pkg::cmd_t cmd
);

    localparam logic [3:0] ST_INIT     = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_CHECK    = 4'd2;
    localparam logic [3:0] ST_REDUCE   = 4'd3;
    localparam logic [3:0] ST_HEAD     = 4'd4;
    localparam logic [3:0] ST_NODE_RD  = 4'd5;
    localparam logic [3:0] ST_NODE_CMP = 4'd6;
    localparam logic [3:0] ST_CLEAR    = 4'd7;
    localparam logic [3:0] ST_DONE     = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_INIT: begin
                cmd.head_clear = 1'b1;
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.idx_big) begin
                    cmd.rem_start = 1'b1;
                    state_next    = ST_REDUCE;
                end else begin
                    case (sts.action)
                        chs_pkg::ACT_INSERT: begin
                            if (!sts.pool_full) begin
                                state_next = ST_HEAD;
                            end else if (sts.out_free) begin
                                cmd.emit      = 1'b1;
                                cmd.emit_full = 1'b1;
                                state_next    = ST_IDLE;
                            end
                        end
                        chs_pkg::ACT_FIND: begin
                            state_next = ST_HEAD;
                        end
                        chs_pkg::ACT_CLEAR: begin
                            state_next = ST_CLEAR;
                        end
                        default: begin
                            if (sts.out_free) begin
                                cmd.emit   = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                    endcase
                end
            end
            ST_REDUCE: begin
                // quotient is registered; subtract it back out
                cmd.rem_step = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_HEAD: begin
                if (sts.action == chs_pkg::ACT_INSERT) begin
                    if (sts.out_free) begin
                        cmd.head_insert = 1'b1;
                        cmd.emit        = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end else if (sts.head_valid) begin
                    cmd.ptr_from_head = 1'b1;
                    state_next        = ST_NODE_RD;
                end else if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_NODE_RD: begin
                state_next = ST_NODE_CMP;
            end
            ST_NODE_CMP: begin
                if (sts.site_match) begin
                    if (sts.out_free) begin
                        cmd.emit       = 1'b1;
                        cmd.emit_found = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else if (sts.link_valid) begin
                    cmd.ptr_from_link = 1'b1;
                    state_next        = ST_NODE_RD;
                end else if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                cmd.head_clear = 1'b1;
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.count_clear = 1'b1;
                    cmd.emit        = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

FILE: rtl/chained_hash_set.sv
// ----------------------------------------------------------------------------
// chained_hash_set
// Hash set of site numbers: bucket heads point into a node pool of chains.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  ---------+-----------+-------------------------------------------------
//  s_       | in        | tuser: action; tdata: site
//  m_       | out       | tdata: found, pool_full, entry_total
//  cfg_     | in        | bucket_mask write, one register
//
//  One item at a time. Insert: check and head-read steps, then the result
//  register; find: the same, plus a read and a compare step per chain node
//  visited (single-port node pool read); clear: one head entry cleared per
//  cycle. A bucket index at or above BUCKETS adds a reduction (reciprocal
//  quotient, subtract). After reset the head table is swept, s_tready low.
//  A stalled result waits in the output register; the next item is accepted
//  meanwhile and holds in its last step until the register frees.
// ----------------------------------------------------------------------------
module chained_hash_set #(
    parameter int BUCKETS   = chs_pkg::BUCKETS_DEF,
    parameter int NODES     = chs_pkg::NODES_DEF,
    parameter int SITE_BITS = chs_pkg::SITE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [chs_pkg::SITE_W-1:0]    s_tdata,   // [31:0] site
    input  logic [chs_pkg::ACTION_W-1:0]  s_tuser,   // [1:0] action
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] found, [1] pool_full, [14:2] entry_total, [15] zero
    output logic [chs_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          cfg_wen,
    input  logic [chs_pkg::MASK_W-1:0]    cfg_wdata  // bucket_mask
);

    chs_pkg::cmd_t                cmd;
    chs_pkg::sts_t                sts;
    logic                         m_found;
    logic                         m_full;
    logic [chs_pkg::TOTAL_W-1:0]  m_total;

    chs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    chs_dp #(
        .BUCKETS   (BUCKETS),
        .NODES     (NODES),
        .SITE_BITS (SITE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_action  (s_tuser),
        .s_site    (s_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_found   (m_found),
        .m_full    (m_full),
        .m_total   (m_total)
    );

    assign m_tdata = {1'b0, m_total, m_full, m_found};

endmodule

FILE: rtl/chs_check.sv
// ----------------------------------------------------------------------------
// chs_check
// Port-level checks of the chained hash set, bound to the top level.
// ----------------------------------------------------------------------------
module chs_check (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [chs_pkg::M_DATA_W-1:0]  m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in flight: ready drops right after a transaction
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while busy");

    // found and pool_full never together
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("found and pool_full both set");

    // a refused insert means the pool holds entries
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[14:2] != 13'd0)
        else $error("pool_full with empty pool");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("activity right after reset");

endmodule

bind chained_hash_set chs_check u_chs_check (.*);
